// File: rtl/core/mtxc_pkg.sv
// shared constants, types and the tempering function of the keystream cipher
package mtxc_pkg;

   localparam int unsigned MT_N = 624;
   localparam int unsigned MT_M = 397;
   localparam int unsigned ADDR_W = $clog2(MT_N);
   localparam int unsigned GIDX_W = $clog2(MT_N + 1);

   localparam logic [31:0] MT_MATRIX    = 32'h9908_B0DF;
   localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
   localparam logic [31:0] MT_TEMPER_B  = 32'h9D2C_5680;
   localparam logic [31:0] MT_TEMPER_C  = 32'hEFC6_0000;

   localparam int unsigned SEED_W = 16;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned BLEFT_W = 3;
   localparam logic [BLEFT_W-1:0] BYTES_PER_WORD = BLEFT_W'(4);

   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MT_N - 1);
   localparam logic [ADDR_W:0]   ADDR_M    = (ADDR_W + 1)'(MT_M);
   localparam logic [ADDR_W:0]   ADDR_N    = (ADDR_W + 1)'(MT_N);
   localparam logic [GIDX_W-1:0] GIDX_FULL = GIDX_W'(MT_N);

   // read address source for the state memory
   typedef enum logic [1:0] {
      RD_ZERO  = 2'd0,
      RD_TWIST = 2'd1,
      RD_GEN   = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic       accept;
      logic       seed_mul;
      logic       seed_add;
      logic       tw_start;
      logic       tw_load;
      logic       tw_write;
      logic       temper;
      logic       consume;
      logic       use_held;
      rd_sel_type rd_sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic bytes_left_zero;
      logic gen_index_full;
      logic cnt_last;
   } ctl_status_type;

   function automatic logic [31:0] mt_temper(input logic [31:0] x);
      logic [31:0] y;
      y = x;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & MT_TEMPER_B);
      y = y ^ ((y << 15) & MT_TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// File: rtl/core/mtxc_ctrl.sv
// controller state machine of the keystream cipher
module mtxc_ctrl
   import mtxc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_first,
   output logic           req_ready,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_SEED_MUL = 10'b00_0000_0010,
      ST_SEED_ADD = 10'b00_0000_0100,
      ST_TW_START = 10'b00_0000_1000,
      ST_TW_LOAD  = 10'b00_0001_0000,
      ST_TW_RD    = 10'b00_0010_0000,
      ST_TW_WR    = 10'b00_0100_0000,
      ST_FETCH    = 10'b00_1000_0000,
      ST_TEMPER   = 10'b01_0000_0000,
      ST_OUT      = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      accept;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_GEN;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               if (req_first) begin
                  state_in = ST_SEED_MUL;
               end else if (status.bytes_left_zero) begin
                  state_in = status.gen_index_full ? ST_TW_START : ST_FETCH;
               end else begin
                  cmd.consume = 1'b1;
               end
            end
         end
         ST_SEED_MUL: begin
            cmd.seed_mul = 1'b1;
            state_in = ST_SEED_ADD;
         end
         ST_SEED_ADD: begin
            cmd.seed_add = 1'b1;
            state_in = status.cnt_last ? ST_TW_START : ST_SEED_MUL;
         end
         ST_TW_START: begin
            cmd.tw_start = 1'b1;
            cmd.rd_sel = RD_ZERO;
            state_in = ST_TW_LOAD;
         end
         ST_TW_LOAD: begin
            cmd.tw_load = 1'b1;
            cmd.rd_sel = RD_TWIST;
            state_in = ST_TW_WR;
         end
         ST_TW_RD: begin
            cmd.rd_sel = RD_TWIST;
            state_in = ST_TW_WR;
         end
         ST_TW_WR: begin
            cmd.tw_write = 1'b1;
            state_in = status.cnt_last ? ST_FETCH : ST_TW_RD;
         end
         ST_FETCH: begin
            cmd.rd_sel = RD_GEN;
            state_in = ST_TEMPER;
         end
         ST_TEMPER: begin
            cmd.temper = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.consume  = 1'b1;
               cmd.use_held = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.consume) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a marked item always starts the seeding pass
   a_first_seeds: assert property (@(posedge clock) disable iff (reset)
      accept && req_first |=> state_ff == ST_SEED_MUL)
      else $error("marked item did not start seeding");

   // the last twist step hands over to the word fetch
   a_twist_to_fetch: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TW_WR && status.cnt_last |=> state_ff == ST_FETCH)
      else $error("twist pass did not end in a fetch");

   // a freshly tempered word leaves bytes in the buffer
   a_temper_fills: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TEMPER |=> !status.bytes_left_zero)
      else $error("tempered word not loaded into buffer");

   // a held item is delivered once the output register frees up
   a_out_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && slot_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("held item not delivered");

endmodule

// File: rtl/core/mtxc_datapath.sv
// datapath of the keystream cipher: state memory, seeding, twist, tempering, byte buffer
module mtxc_datapath
   import mtxc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [SEED_W-1:0]   csr_wr_data,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_first,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   input  ctl_cmd_type         cmd,
   output ctl_status_type      status
);

   logic [31:0] gen_state_mem [MT_N];

   logic [SEED_W-1:0]  key_seed_ff;
   logic [GIDX_W-1:0]  gen_index_ff, gen_index_in;
   logic [31:0]        word_buf_ff, word_buf_in;
   logic [BLEFT_W-1:0] bytes_left_ff, bytes_left_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]        prev_ff, prev_in;
   logic [31:0]        prod_ff;
   logic [31:0]        cur_ff, cur_in;
   logic [BYTE_W-1:0]  data_ff;
   logic [BYTE_W-1:0]  rsp_out_byte_ff;
   logic [31:0]        rd_a_ff, rd_b_ff;

   logic [ADDR_W-1:0]  addr_a, addr_b, cnt_next;
   logic [ADDR_W:0]    sum_b;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic [31:0]        mem_wd;
   logic [31:0]        mix, prod_in, seed_word;
   logic [31:0]        tw_y, tw_v, tempered;
   logic [BYTE_W-1:0]  src_byte;

   assign cnt_next = (cnt_ff == ADDR_LAST) ? '0 : cnt_ff + 1'b1;
   assign sum_b    = {1'b0, cnt_ff} + ADDR_M;

   // read addresses
   always_comb begin
      addr_b = (sum_b >= ADDR_N) ? ADDR_W'(sum_b - ADDR_N) : sum_b[ADDR_W-1:0];
      case (cmd.rd_sel)
         RD_ZERO:  addr_a = '0;
         RD_TWIST: addr_a = cnt_next;
         default:  addr_a = gen_index_ff[ADDR_W-1:0];
      endcase
   end

   // seeding recurrence, split around the multiplier register
   assign mix       = prev_ff ^ (prev_ff >> 30);
   assign prod_in   = MT_INIT_MULT * mix;
   assign seed_word = prod_ff + 32'(cnt_ff);

   // twist step, in place
   assign tw_y = {cur_ff[31], rd_a_ff[30:0]};
   assign tw_v = rd_b_ff ^ (tw_y >> 1) ^ (tw_y[0] ? MT_MATRIX : 32'h0);

   assign tempered = mt_temper(rd_a_ff);
   assign src_byte = cmd.use_held ? data_ff : req_data_byte;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = cnt_ff;
      mem_wd = tw_v;
      if (cmd.accept && req_first) begin
         mem_we = 1'b1;
         mem_wa = '0;
         mem_wd = 32'(key_seed_ff);
      end else if (cmd.seed_add) begin
         mem_we = 1'b1;
         mem_wd = seed_word;
      end else if (cmd.tw_write) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      gen_index_in  = gen_index_ff;
      word_buf_in   = word_buf_ff;
      bytes_left_in = bytes_left_ff;
      cnt_in        = cnt_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      if (cmd.accept && req_first) begin
         word_buf_in   = '0;
         bytes_left_in = '0;
         gen_index_in  = GIDX_FULL;
         prev_in       = 32'(key_seed_ff);
         cnt_in        = ADDR_W'(1);
      end
      if (cmd.seed_add) begin
         prev_in = seed_word;
         cnt_in  = cnt_next;
      end
      if (cmd.tw_start) begin
         cnt_in = '0;
      end
      if (cmd.tw_load) begin
         cur_in = rd_a_ff;
      end
      if (cmd.tw_write) begin
         cur_in = rd_a_ff;
         cnt_in = cnt_next;
         if (cnt_ff == ADDR_LAST) begin
            gen_index_in = '0;
         end
      end
      if (cmd.temper) begin
         word_buf_in   = tempered;
         bytes_left_in = BYTES_PER_WORD;
         gen_index_in  = gen_index_ff + 1'b1;
      end
      if (cmd.consume) begin
         word_buf_in   = word_buf_ff >> BYTE_W;
         bytes_left_in = bytes_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_seed_ff   <= '0;
         gen_index_ff  <= GIDX_FULL;
         word_buf_ff   <= '0;
         bytes_left_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            key_seed_ff <= csr_wr_data;
         end
         gen_index_ff  <= gen_index_in;
         word_buf_ff   <= word_buf_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      if (cmd.seed_mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.accept) begin
         data_ff <= req_data_byte;
      end
      if (cmd.consume) begin
         rsp_out_byte_ff <= src_byte ^ word_buf_ff[BYTE_W-1:0];
      end
   end

   // state memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         gen_state_mem[mem_wa] <= mem_wd;
      end
      rd_a_ff <= gen_state_mem[addr_a];
      rd_b_ff <= gen_state_mem[addr_b];
   end

   assign rsp_out_byte = rsp_out_byte_ff;

   assign status.bytes_left_zero = (bytes_left_ff == '0);
   assign status.gen_index_full  = (gen_index_ff >= GIDX_FULL);
   assign status.cnt_last        = (cnt_ff == ADDR_LAST);

endmodule

// File: rtl/core/mt19937_keystream_xor_cipher.sv
// top level of the mt19937 keystream xor byte cipher
//
// usage
//   req channel: one byte per item (req_data_byte) plus req_first, which restarts
//   the stream: the generator is re-seeded from the key register before that byte
//   rsp channel: one rsp_out_byte per item, in order; encrypt and decrypt are the same
//   csr port: csr_wr_en writes csr_wr_data into the 16-bit key register at once;
//   the new key is used from the next item marked first
// timing
//   a byte served from the buffered keystream word: accepted, result in the output
//   register in the next cycle; one item per cycle on three of every four bytes
//   while rsp_ready is high; a byte that needs a new word: memory read, tempering,
//   delivery; a twist of the 624-word state: a read state and a write state per
//   word over the one write port and two read ports of the state memory, once
//   every 624 words; an item marked first: seeding (multiplier register then add
//   per word) plus the twist and the word fetch
// reset
//   clears the key, the byte buffer and the control state; the state memory is
//   not cleared, so the first item after reset must be marked first
// stalls
//   the result waits in the output register while rsp_ready is low; a new item is
//   taken only when that register is free or being emptied in the same cycle
module mt19937_keystream_xor_cipher
   import mtxc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // key register
   input  logic              csr_wr_en,
   input  logic [SEED_W-1:0] csr_wr_data,
   // input items
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_first,
   // result items
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   // sequencing of seeding, twist, fetch and delivery
   mtxc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_first (req_first),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // generator state, keystream buffer and output register
   mtxc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_data_byte (req_data_byte),
      .req_first     (req_first),
      .rsp_out_byte  (rsp_out_byte),
      .cmd           (cmd),
      .status        (status)
   );

endmodule
